### sv/tamg_pkg.sv
package tamg_pkg;

    // Store dimensions
    localparam int MAX_VERTICES = 64;
    localparam int VIDX_W       = 6;
    localparam int CNT_W        = 7;
    localparam int EDGE_W       = 11;
    localparam int ROW_W        = 64;

    typedef enum logic [2:0] {
        CMD_ADD_EDGE  = 3'd0,
        CMD_REM_EDGE  = 3'd1,
        CMD_QUERY     = 3'd2,
        CMD_DEGREE    = 3'd3,
        CMD_NEIGHBORS = 3'd4,
        CMD_ADD_VERT  = 3'd5,
        CMD_REM_VERT  = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOVERT  = 3'd1,
        ST_LOOP    = 3'd2,
        ST_EXISTS  = 3'd3,
        ST_MISSING = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EDGE,
        S_ROWA,
        S_SWEEP,
        S_SWEEP_EV,
        S_SHIFT,
        S_SHIFT_WR,
        S_EMIT
    } state_t;

endpackage

### sv/triangular_adjacency_matrix_graph.sv
// Undirected graph store, lower-triangular bit matrix in a 64 x 64-bit RAM.
// Input channel (in_valid/in_ready) takes one command beat: cmd, vertex_a,
// vertex_b. Output channel (out_valid/out_ready) returns result beats with
// status, answer, answer_valid, last and the edge/vertex totals after the
// command. Every command gives one beat, except neighbour listing which
// gives one beat per neighbour (last on the final one) or a single empty
// beat.
// One command is in flight at a time; in_ready is high only when idle.
// Degree and neighbour listing walk the vertices one at a time: those below
// vertex_a from its own row, the higher ones by reading their rows through
// the single RAM read port. Remove vertex adds a second pass that copies
// each higher row down one place, a read and a write per row.
// A stalled receiver holds the output register; the sweep pauses until the
// beat is taken. Reset clears the row valid bits, the counters and all
// control, giving an empty store with zero vertices.
module triangular_adjacency_matrix_graph (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  cmd,
    input  logic [5:0]  vertex_a,
    input  logic [5:0]  vertex_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [6:0]  answer,
    output logic        answer_valid,
    output logic        last,
    output logic [10:0] edge_total,
    output logic [6:0]  vertex_total
);

    localparam int VW = tamg_pkg::VIDX_W;
    localparam int CW = tamg_pkg::CNT_W;
    localparam int EW = tamg_pkg::EDGE_W;
    localparam int RW = tamg_pkg::ROW_W;

    // Remove bit pos from a row, moving higher bits down one place
    function automatic logic [RW-1:0] drop_bit(input logic [RW-1:0] w,
                                               input logic [VW-1:0] pos);
        logic [RW-1:0] keep;
        begin
            keep     = ({{(RW-1){1'b0}}, 1'b1} << pos) - {{(RW-1){1'b0}}, 1'b1};
            drop_bit = (w & keep) | ((w >> 1) & ~keep);
        end
    endfunction

    tamg_pkg::state_t  state_reg, state_next;
    tamg_pkg::cmd_t    cmd_reg, cmd_next;
    logic [VW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [CW-1:0]     vc_reg, vc_next;
    logic [EW-1:0]     edge_reg, edge_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [VW-1:0]     pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [RW-1:0]     rowa_reg, rowa_next;
    tamg_pkg::status_t res_status_reg, res_status_next;
    logic [CW-1:0]     res_answer_reg, res_answer_next;
    logic              res_av_reg, res_av_next;

    // Output register
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [CW-1:0]     answer_reg;
    logic              av_reg, last_reg;
    logic [EW-1:0]     edge_total_reg;
    logic [CW-1:0]     vertex_total_reg;
    logic              out_load;
    tamg_pkg::status_t load_status;
    logic [CW-1:0]     load_answer;
    logic              load_av, load_last;

    // Row store and its valid bits
    logic [RW-1:0]     mem [RW];
    logic [RW-1:0]     row_valid_reg;
    logic [RW-1:0]     rd_data_reg;
    logic              rd_valid_reg;
    logic              rd_en, wr_en, clr_en;
    logic [VW-1:0]     rd_addr, wr_addr, clr_addr;
    logic [RW-1:0]     wr_data;

    // Shared decode
    logic [RW-1:0]     eff_rd;
    logic [VW-1:0]     hi_idx, lo_idx, i_lo;
    logic              a_ok, b_ok, slot_free, sweep_done, i_gt_a;
    logic              sweep_bit, sweep_eval, hit, stall, shift_more;

    assign eff_rd     = rd_valid_reg ? rd_data_reg : '0;
    assign hi_idx     = (a_reg > b_reg) ? a_reg : b_reg;
    assign lo_idx     = (a_reg > b_reg) ? b_reg : a_reg;
    assign a_ok       = {1'b0, a_reg} < vc_reg;
    assign b_ok       = {1'b0, b_reg} < vc_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    assign i_lo       = i_reg[VW-1:0];
    assign sweep_done = i_reg >= vc_reg;
    assign i_gt_a     = i_reg > {1'b0, a_reg};
    assign shift_more = (i_reg + {{(CW-1){1'b0}}, 1'b1}) < vc_reg;
    assign sweep_bit  = (state_reg == tamg_pkg::S_SWEEP_EV) ? eff_rd[a_reg]
                      : ((i_reg < {1'b0, a_reg}) && rowa_reg[i_lo]);
    assign sweep_eval = (state_reg == tamg_pkg::S_SWEEP_EV)
                     || ((state_reg == tamg_pkg::S_SWEEP) && !sweep_done && !i_gt_a);
    assign hit        = sweep_eval && sweep_bit;
    assign stall      = hit && (cmd_reg == tamg_pkg::CMD_NEIGHBORS)
                     && pend_valid_reg && !slot_free;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tamg_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = tamg_pkg::S_DECODE;
            end
            tamg_pkg::S_DECODE:
            begin
                unique case (cmd_reg)
                    tamg_pkg::CMD_ADD_EDGE, tamg_pkg::CMD_REM_EDGE, tamg_pkg::CMD_QUERY:
                        state_next = (!a_ok || !b_ok || a_reg == b_reg)
                                   ? tamg_pkg::S_EMIT : tamg_pkg::S_EDGE;
                    tamg_pkg::CMD_DEGREE, tamg_pkg::CMD_NEIGHBORS, tamg_pkg::CMD_REM_VERT:
                        state_next = a_ok ? tamg_pkg::S_ROWA : tamg_pkg::S_EMIT;
                    default:
                        state_next = tamg_pkg::S_EMIT;
                endcase
            end
            tamg_pkg::S_EDGE:
                state_next = tamg_pkg::S_EMIT;
            tamg_pkg::S_ROWA:
                state_next = tamg_pkg::S_SWEEP;
            tamg_pkg::S_SWEEP:
            begin
                if (sweep_done)
                    state_next = (cmd_reg == tamg_pkg::CMD_REM_VERT)
                               ? tamg_pkg::S_SHIFT : tamg_pkg::S_EMIT;
                else if (i_gt_a)
                    state_next = tamg_pkg::S_SWEEP_EV;
            end
            tamg_pkg::S_SWEEP_EV:
            begin
                if (!stall)
                    state_next = tamg_pkg::S_SWEEP;
            end
            tamg_pkg::S_SHIFT:
                state_next = shift_more ? tamg_pkg::S_SHIFT_WR : tamg_pkg::S_EMIT;
            tamg_pkg::S_SHIFT_WR:
                state_next = tamg_pkg::S_SHIFT;
            tamg_pkg::S_EMIT:
            begin
                if (slot_free)
                    state_next = tamg_pkg::S_IDLE;
            end
            default:
                state_next = tamg_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        vc_next         = vc_reg;
        edge_next       = edge_reg;
        i_next          = i_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        rowa_next       = rowa_reg;
        res_status_next = res_status_reg;
        res_answer_next = res_answer_reg;
        res_av_next     = res_av_reg;
        rd_en           = 1'b0;
        rd_addr         = a_reg;
        wr_en           = 1'b0;
        wr_addr         = i_lo;
        wr_data         = '0;
        clr_en          = 1'b0;
        clr_addr        = vc_reg[VW-1:0];
        out_load        = 1'b0;
        load_status     = tamg_pkg::ST_OK;
        load_answer     = '0;
        load_av         = 1'b0;
        load_last       = 1'b1;

        unique case (state_reg)
            tamg_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next = tamg_pkg::cmd_t'(cmd);
                    a_next   = vertex_a;
                    b_next   = vertex_b;
                end
            end
            tamg_pkg::S_DECODE:
            begin
                res_status_next = tamg_pkg::ST_OK;
                res_answer_next = '0;
                res_av_next     = 1'b0;
                i_next          = '0;
                cnt_next        = '0;
                pend_valid_next = 1'b0;
                unique case (cmd_reg)
                    tamg_pkg::CMD_ADD_EDGE, tamg_pkg::CMD_REM_EDGE, tamg_pkg::CMD_QUERY:
                    begin
                        if (!a_ok || !b_ok)
                            res_status_next = tamg_pkg::ST_NOVERT;
                        else if (a_reg == b_reg)
                        begin
                            if (cmd_reg == tamg_pkg::CMD_ADD_EDGE)
                                res_status_next = tamg_pkg::ST_LOOP;
                            else if (cmd_reg == tamg_pkg::CMD_REM_EDGE)
                                res_status_next = tamg_pkg::ST_MISSING;
                            else
                                res_av_next = 1'b1;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = hi_idx;
                        end
                    end
                    tamg_pkg::CMD_DEGREE, tamg_pkg::CMD_NEIGHBORS, tamg_pkg::CMD_REM_VERT:
                    begin
                        if (!a_ok)
                            res_status_next = tamg_pkg::ST_NOVERT;
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = a_reg;
                        end
                    end
                    tamg_pkg::CMD_ADD_VERT:
                    begin
                        if (vc_reg >= CW'(tamg_pkg::MAX_VERTICES))
                            res_status_next = tamg_pkg::ST_FULL;
                        else
                        begin
                            clr_en   = 1'b1;
                            clr_addr = vc_reg[VW-1:0];
                            vc_next  = vc_reg + {{(CW-1){1'b0}}, 1'b1};
                        end
                    end
                    default:
                        res_status_next = tamg_pkg::ST_OK;
                endcase
            end
            tamg_pkg::S_EDGE:
            begin
                wr_addr = hi_idx;
                unique case (cmd_reg)
                    tamg_pkg::CMD_ADD_EDGE:
                    begin
                        if (eff_rd[lo_idx])
                            res_status_next = tamg_pkg::ST_EXISTS;
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_data   = eff_rd | ({{(RW-1){1'b0}}, 1'b1} << lo_idx);
                            edge_next = edge_reg + {{(EW-1){1'b0}}, 1'b1};
                        end
                    end
                    tamg_pkg::CMD_REM_EDGE:
                    begin
                        if (!eff_rd[lo_idx])
                            res_status_next = tamg_pkg::ST_MISSING;
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_data   = eff_rd & ~({{(RW-1){1'b0}}, 1'b1} << lo_idx);
                            edge_next = edge_reg - {{(EW-1){1'b0}}, 1'b1};
                        end
                    end
                    default:
                    begin
                        res_answer_next = {{(CW-1){1'b0}}, eff_rd[lo_idx]};
                        res_av_next     = 1'b1;
                    end
                endcase
            end
            tamg_pkg::S_ROWA:
                rowa_next = eff_rd;
            tamg_pkg::S_SWEEP, tamg_pkg::S_SWEEP_EV:
            begin
                if (state_reg == tamg_pkg::S_SWEEP && sweep_done)
                begin
                    res_status_next = tamg_pkg::ST_OK;
                    unique case (cmd_reg)
                        tamg_pkg::CMD_DEGREE:
                        begin
                            res_answer_next = cnt_reg;
                            res_av_next     = 1'b1;
                        end
                        tamg_pkg::CMD_NEIGHBORS:
                        begin
                            res_answer_next = pend_valid_reg ? {1'b0, pend_reg} : '0;
                            res_av_next     = pend_valid_reg;
                        end
                        default:
                        begin
                            edge_next = edge_reg - {{(EW-CW){1'b0}}, cnt_reg};
                            i_next    = {1'b0, a_reg};
                        end
                    endcase
                end
                else if (state_reg == tamg_pkg::S_SWEEP && i_gt_a)
                begin
                    rd_en   = 1'b1;
                    rd_addr = i_lo;
                end
                else if (!stall)
                begin
                    // One vertex checked; hand out the previous neighbour on a hit
                    i_next = i_reg + {{(CW-1){1'b0}}, 1'b1};
                    if (hit)
                    begin
                        cnt_next = cnt_reg + {{(CW-1){1'b0}}, 1'b1};
                        if (cmd_reg == tamg_pkg::CMD_NEIGHBORS)
                        begin
                            pend_next       = i_lo;
                            pend_valid_next = 1'b1;
                            if (pend_valid_reg)
                            begin
                                out_load    = 1'b1;
                                load_answer = {1'b0, pend_reg};
                                load_av     = 1'b1;
                                load_last   = 1'b0;
                            end
                        end
                    end
                end
            end
            tamg_pkg::S_SHIFT:
            begin
                if (shift_more)
                begin
                    rd_en   = 1'b1;
                    rd_addr = i_lo + {{(VW-1){1'b0}}, 1'b1};
                end
                else
                begin
                    clr_en          = 1'b1;
                    clr_addr        = i_lo;
                    vc_next         = vc_reg - {{(CW-1){1'b0}}, 1'b1};
                    res_status_next = tamg_pkg::ST_OK;
                    res_answer_next = '0;
                    res_av_next     = 1'b0;
                end
            end
            tamg_pkg::S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = i_lo;
                wr_data = drop_bit(eff_rd, a_reg);
                i_next  = i_reg + {{(CW-1){1'b0}}, 1'b1};
            end
            tamg_pkg::S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load    = 1'b1;
                    load_status = res_status_reg;
                    load_answer = res_answer_reg;
                    load_av     = res_av_reg;
                end
            end
            default:
                in_ready = 1'b0;
        endcase
    end

    // Control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tamg_pkg::S_IDLE;
            cmd_reg        <= tamg_pkg::CMD_ADD_EDGE;
            vc_reg         <= '0;
            edge_reg       <= '0;
            i_reg          <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            vc_reg         <= vc_next;
            edge_reg       <= edge_next;
            i_reg          <= i_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            if (wr_en)
                row_valid_reg[wr_addr] <= 1'b1;
            if (clr_en)
                row_valid_reg[clr_addr] <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        pend_reg       <= pend_next;
        rowa_reg       <= rowa_next;
        res_status_reg <= res_status_next;
        res_answer_reg <= res_answer_next;
        res_av_reg     <= res_av_next;
        if (out_load)
        begin
            status_reg       <= load_status;
            answer_reg       <= load_answer;
            av_reg           <= load_av;
            last_reg         <= load_last;
            edge_total_reg   <= edge_next;
            vertex_total_reg <= vc_next;
        end
    end

    // Row RAM: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign answer       = answer_reg;
    assign answer_valid = av_reg;
    assign last         = last_reg;
    assign edge_total   = edge_total_reg;
    assign vertex_total = vertex_total_reg;

    // Checks
    a_vc_range: assert property (@(posedge clk) disable iff (!rst_n)
        vc_reg <= CW'(tamg_pkg::MAX_VERTICES))
        else $error("vertex count beyond store size");

    a_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !answer_valid) |-> (answer == '0))
        else $error("answer not zero on beat without value");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != 3'(tamg_pkg::ST_OK)) |-> last)
        else $error("error beat not marked last");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second command taken while busy");

endmodule

### bench/triangular_adjacency_matrix_graph_tb.sv
module triangular_adjacency_matrix_graph_tb;

    // Command code that the block must ignore
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 225;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  answer;
        logic        answer_valid;
        logic        last;
        logic [10:0] edge_total;
        logic [6:0]  vertex_total;
    } graph_result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  cmd;
    logic [5:0]  vertex_a;
    logic [5:0]  vertex_b;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [6:0]  answer;
    logic        answer_valid;
    logic        last;
    logic [10:0] edge_total;
    logic [6:0]  vertex_total;

    // Mirror of the store
    logic [63:0]   tri_rows [64];
    int            vert_count;
    int            edge_count;
    graph_result_t pending_results [$];

    int  error_count;
    int  beats_sent;
    int  beats_seen;
    int  idle_cycles;
    bit  valid_held;
    int  burst_left;
    int  gap_left;

    triangular_adjacency_matrix_graph DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .vertex_a     (vertex_a),
        .vertex_b     (vertex_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .answer       (answer),
        .answer_valid (answer_valid),
        .last         (last),
        .edge_total   (edge_total),
        .vertex_total (vertex_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Is the pair joined in the mirror
    function automatic bit joined(int a, int b);
        int hi;
        int lo;
        if (a == b)
            return 1'b0;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        return tri_rows[hi][lo];
    endfunction

    function automatic void set_joined(int a, int b, bit on);
        int hi;
        int lo;
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
        tri_rows[hi][lo] = on;
    endfunction

    function automatic void push_result(tamg_pkg::status_t st, int ans, bit aval, bit lst);
        graph_result_t r;
        r.status       = st;
        r.answer       = ans[6:0];
        r.answer_valid = aval;
        r.last         = lst;
        r.edge_total   = edge_count[10:0];
        r.vertex_total = vert_count[6:0];
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Apply one command to the mirror and queue the beats it should produce
    function automatic void apply_graph_cmd(logic [2:0] c, int a, int b);
        int          n;
        int          lost;
        int          oi;
        int          oj;
        logic [63:0] fresh [64];
        n = 0;
        lost = 0;
        case (c)
            tamg_pkg::CMD_ADD_EDGE:
            begin
                if (a >= vert_count || b >= vert_count)
                    push_result(tamg_pkg::ST_NOVERT, 0, 0, 1);
                else if (a == b)
                    push_result(tamg_pkg::ST_LOOP, 0, 0, 1);
                else if (joined(a, b))
                    push_result(tamg_pkg::ST_EXISTS, 0, 0, 1);
                else
                begin
                    set_joined(a, b, 1'b1);
                    edge_count = (edge_count + 1) & 2047;
                    push_result(tamg_pkg::ST_OK, 0, 0, 1);
                end
            end
            tamg_pkg::CMD_REM_EDGE:
            begin
                if (a >= vert_count || b >= vert_count)
                    push_result(tamg_pkg::ST_NOVERT, 0, 0, 1);
                else if (!joined(a, b))
                    push_result(tamg_pkg::ST_MISSING, 0, 0, 1);
                else
                begin
                    set_joined(a, b, 1'b0);
                    edge_count = (edge_count - 1) & 2047;
                    push_result(tamg_pkg::ST_OK, 0, 0, 1);
                end
            end
            tamg_pkg::CMD_QUERY:
            begin
                if (a >= vert_count || b >= vert_count)
                    push_result(tamg_pkg::ST_NOVERT, 0, 0, 1);
                else
                    push_result(tamg_pkg::ST_OK, joined(a, b), 1, 1);
            end
            tamg_pkg::CMD_DEGREE:
            begin
                if (a >= vert_count)
                    push_result(tamg_pkg::ST_NOVERT, 0, 0, 1);
                else
                begin
                    for (int i = 0; i < vert_count; i++)
                        if (joined(a, i))
                            n++;
                    push_result(tamg_pkg::ST_OK, n, 1, 1);
                end
            end
            tamg_pkg::CMD_NEIGHBORS:
            begin
                if (a >= vert_count)
                    push_result(tamg_pkg::ST_NOVERT, 0, 0, 1);
                else
                begin
                    for (int i = 0; i < vert_count; i++)
                        if (joined(a, i))
                        begin
                            push_result(tamg_pkg::ST_OK, i, 1, 0);
                            n++;
                        end
                    if (n == 0)
                        push_result(tamg_pkg::ST_OK, 0, 0, 1);
                    else
                        pending_results[$].last = 1'b1;
                end
            end
            tamg_pkg::CMD_ADD_VERT:
            begin
                if (vert_count >= tamg_pkg::MAX_VERTICES)
                    push_result(tamg_pkg::ST_FULL, 0, 0, 1);
                else
                begin
                    tri_rows[vert_count] = '0;
                    vert_count++;
                    push_result(tamg_pkg::ST_OK, 0, 0, 1);
                end
            end
            tamg_pkg::CMD_REM_VERT:
            begin
                if (a >= vert_count)
                    push_result(tamg_pkg::ST_NOVERT, 0, 0, 1);
                else
                begin
                    for (int i = 0; i < vert_count; i++)
                        if (joined(a, i))
                            lost++;
                    foreach (fresh[i])
                        fresh[i] = '0;
                    // higher vertices shift down by one
                    for (int i = 0; i + 1 < vert_count; i++)
                    begin
                        oi = (i < a) ? i : i + 1;
                        for (int j = 0; j < i; j++)
                        begin
                            oj = (j < a) ? j : j + 1;
                            if (joined(oi, oj))
                                fresh[i][j] = 1'b1;
                        end
                    end
                    tri_rows = fresh;
                    vert_count--;
                    edge_count = (edge_count - lost) & 2047;
                    push_result(tamg_pkg::ST_OK, 0, 0, 1);
                end
            end
            default:
                push_result(tamg_pkg::ST_OK, 0, 0, 1);
        endcase
    endfunction

    // Send one command beat, in bursts with random gaps
    task automatic send_cmd(logic [2:0] c, int a, int b);
        if (!valid_held)
            repeat (gap_left) @(posedge clk);
        in_valid   <= 1'b1;
        valid_held = 1'b1;
        cmd        <= c;
        vertex_a   <= a[5:0];
        vertex_b   <= b[5:0];
        do
            @(posedge clk);
        while (!in_ready);
        apply_graph_cmd(c, a, b);
        beats_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
            gap_left   = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 6);
        end
    endtask

    task automatic release_input();
        if (valid_held)
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
        end
    endtask

    // Hold off until every queued beat has come back
    task automatic drain_results();
        release_input();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_vertex();
        if (vert_count > 0 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, vert_count - 1);
        return $urandom_range(0, 63);
    endfunction

    // Every command but add vertex, plus the unused code, against an empty store
    task automatic test_empty_store();
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 0, 1);
        send_cmd(tamg_pkg::CMD_REM_EDGE, 63, 63);
        send_cmd(tamg_pkg::CMD_QUERY, 0, 0);
        send_cmd(tamg_pkg::CMD_DEGREE, 0, 0);
        send_cmd(tamg_pkg::CMD_NEIGHBORS, 63, 0);
        send_cmd(tamg_pkg::CMD_REM_VERT, 0, 0);
        send_cmd(CMD_UNUSED, 63, 63);
    endtask

    // Status codes and the small-graph corner cases
    task automatic test_edge_cases();
        repeat (4) send_cmd(tamg_pkg::CMD_ADD_VERT, 0, 0);
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 0, 3);
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 3, 0);
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 2, 2);
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 1, 4);
        send_cmd(tamg_pkg::CMD_REM_EDGE, 1, 1);
        send_cmd(tamg_pkg::CMD_REM_EDGE, 1, 2);
        send_cmd(tamg_pkg::CMD_QUERY, 3, 0);
        send_cmd(tamg_pkg::CMD_QUERY, 2, 2);
        send_cmd(tamg_pkg::CMD_DEGREE, 0, 0);
        send_cmd(tamg_pkg::CMD_NEIGHBORS, 1, 0);
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 1, 2);
        send_cmd(tamg_pkg::CMD_REM_VERT, 1, 0);
        send_cmd(tamg_pkg::CMD_NEIGHBORS, 2, 0);
        send_cmd(tamg_pkg::CMD_REM_VERT, 4, 0);
    endtask

    // Fill to capacity and exercise the top vertex
    task automatic test_full_store();
        while (vert_count < tamg_pkg::MAX_VERTICES)
            send_cmd(tamg_pkg::CMD_ADD_VERT, 0, 0);
        send_cmd(tamg_pkg::CMD_ADD_VERT, 0, 0);
        for (int i = 0; i < 63; i++)
            send_cmd(tamg_pkg::CMD_ADD_EDGE, 63, i);
        send_cmd(tamg_pkg::CMD_ADD_EDGE, 0, 62);
        send_cmd(tamg_pkg::CMD_DEGREE, 63, 0);
        send_cmd(tamg_pkg::CMD_NEIGHBORS, 63, 0);
        send_cmd(tamg_pkg::CMD_QUERY, 0, 63);
        send_cmd(tamg_pkg::CMD_REM_EDGE, 0, 63);
        send_cmd(tamg_pkg::CMD_REM_VERT, 0, 0);
        send_cmd(tamg_pkg::CMD_ADD_VERT, 0, 0);
    endtask

    // Weighted random traffic, mostly on vertices that exist
    task automatic test_random_traffic();
        int          sel;
        int          a;
        int          b;
        logic [2:0]  c;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 2)
                drain_results();
            sel = $urandom_range(0, 99);
            a = pick_vertex();
            b = pick_vertex();
            if (sel < 35)
                c = tamg_pkg::CMD_ADD_EDGE;
            else if (sel < 47)
            begin
                c = tamg_pkg::CMD_REM_EDGE;
                // look for an edge that is actually there
                for (int t = 0; t < 8 && !joined(a, b); t++)
                begin
                    a = pick_vertex();
                    b = pick_vertex();
                end
            end
            else if (sel < 62)
                c = tamg_pkg::CMD_QUERY;
            else if (sel < 70)
                c = tamg_pkg::CMD_DEGREE;
            else if (sel < 78)
                c = tamg_pkg::CMD_NEIGHBORS;
            else if (sel < 88)
                c = tamg_pkg::CMD_ADD_VERT;
            else if (sel < 96)
                c = tamg_pkg::CMD_REM_VERT;
            else
                c = 3'($urandom_range(0, 7));
            send_cmd(c, a, b);
        end
        release_input();
    endtask

    // Receiver stall pattern: always ready, or ready at random three times in four or one time in four
    initial
    begin
        int mode;
        out_ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(30, 200))
            begin
                @(posedge clk);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        graph_result_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            beats_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status exp %0d got %0d", exp_r.status, status);
                    error_count++;
                end
                if (answer !== exp_r.answer)
                begin
                    $error("answer exp %0d got %0d", exp_r.answer, answer);
                    error_count++;
                end
                if (answer_valid !== exp_r.answer_valid)
                begin
                    $error("answer_valid exp %0d got %0d", exp_r.answer_valid,
                           answer_valid);
                    error_count++;
                end
                if (last !== exp_r.last)
                begin
                    $error("last exp %0d got %0d", exp_r.last, last);
                    error_count++;
                end
                if (edge_total !== exp_r.edge_total)
                begin
                    $error("edge_total exp %0d got %0d", exp_r.edge_total,
                           edge_total);
                    error_count++;
                end
                if (vertex_total !== exp_r.vertex_total)
                begin
                    $error("vertex_total exp %0d got %0d", exp_r.vertex_total,
                           vertex_total);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("triangular_adjacency_matrix_graph_tb: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        cmd         <= '0;
        vertex_a    <= '0;
        vertex_b    <= '0;
        error_count = 0;
        beats_sent  = 0;
        beats_seen  = 0;
        idle_cycles = 0;
        valid_held  = 1'b0;
        burst_left  = 0;
        gap_left    = 0;
        vert_count  = 0;
        edge_count  = 0;
        foreach (tri_rows[i])
            tri_rows[i] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_store();
        test_edge_cases();
        drain_results();
        test_full_store();
        test_random_traffic();

        drain_results();
        repeat (300) @(posedge clk);
        $display("sent %0d commands, checked %0d result beats", beats_sent, beats_seen);
        $display("ended with %0d vertices and %0d edges", vert_count, edge_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("triangular_adjacency_matrix_graph_tb: clean");
        else
            $display("triangular_adjacency_matrix_graph_tb: errors");
        $finish;
    end

endmodule
